// ===== hw/rtl/array_sorter_macros.svh =====
// Assertion macros shared by the array sorter RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ARRAY_SORTER_MACROS_SVH
`define ARRAY_SORTER_MACROS_SVH

`ifndef SYNTHESIS
`define AS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("array_sorter assertion failed");
`define AS_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("array_sorter forbidden condition");
`else
`define AS_ASSERT(lbl, clk, rst, prop)
`define AS_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ===== hw/rtl/asort_pkg.sv =====
// Package for the array sorter: payload structs, controller commands,
// state codes and sizing constants. Depends on nothing.
package asort_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int COUNT_W      = $clog2(MAX_ELEMENTS + 1);

   typedef struct packed {
      logic signed [31:0] value;
      logic               last_item;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               last_result;
      logic               overflowed;
   } rsp_payload_type;

   typedef struct packed {
      logic insert;
      logic drop;
      logic pop;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic count_one;
   } dp_status_type;

   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

endpackage

// ===== hw/rtl/asort_datapath.sv =====
// Datapath of the array sorter: insertion cell chain, element counter,
// overflow flag and result register. Depends on asort_pkg and the macro header.
`include "array_sorter_macros.svh"

module asort_datapath
   import asort_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  dp_cmd_type      cmd,
   input  req_payload_type req_payload,
   output dp_status_type   status,
   output rsp_payload_type rsp_payload
);

   logic signed [31:0] cells_ff [MAX_ELEMENTS];
   logic signed [31:0] cells_in [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-1:0] gt;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic overflow_ff, overflow_in;
   rsp_payload_type rsp_ff, rsp_in;

   // An empty cell behaves as if it held a value above every input.
   always_comb begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         gt[i] = (COUNT_W'(i) >= count_ff) || (cells_ff[i] > req_payload.value);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         cells_in[i] = cells_ff[i];
         if (cmd.insert) begin
            if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
               cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
            end else if (gt[i]) begin
               cells_in[i] = req_payload.value;
            end
         end else if (cmd.pop && i < MAX_ELEMENTS - 1) begin
            cells_in[i] = cells_ff[(i < MAX_ELEMENTS - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      rsp_in      = rsp_ff;
      if (cmd.insert) begin
         count_in = count_ff + COUNT_W'(1);
      end
      if (cmd.drop) begin
         overflow_in = 1'b1;
      end
      if (cmd.pop) begin
         count_in            = count_ff - COUNT_W'(1);
         rsp_in.sorted_value = cells_ff[0];
         rsp_in.last_result  = status.count_one;
         rsp_in.overflowed   = overflow_ff;
         if (status.count_one) begin
            overflow_in = 1'b0;
         end
      end
   end

   assign status.full      = (count_ff == COUNT_W'(MAX_ELEMENTS));
   assign status.count_one = (count_ff == COUNT_W'(1));
   assign rsp_payload      = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
      rsp_ff <= rsp_in;
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
         cells_ff[i] <= cells_in[i];
      end
   end

   `AS_NEVER(a_count_bound, clock, reset, count_ff > COUNT_W'(MAX_ELEMENTS))
   `AS_NEVER(a_pop_empty, clock, reset, cmd.pop && count_ff == '0)
   `AS_NEVER(a_insert_pop, clock, reset, cmd.insert && cmd.pop)
   `AS_ASSERT(a_set_done, clock, reset,
              cmd.pop && status.count_one |=> count_ff == '0 && !overflow_ff)

endmodule

// ===== hw/rtl/asort_ctrl.sv =====
// Controller of the array sorter: load and emit state machine and the
// result valid flag. Depends on asort_pkg.
module asort_ctrl
   import asort_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_last_item,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_xfer;

   assign req_ready = (state_ff == ST_LOAD);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.insert = req_xfer && !status.full;
      cmd.drop   = req_xfer && status.full;
      cmd.pop    = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_xfer && req_last_item) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.pop && status.count_one) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      if (cmd.pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/array_sorter.sv =====
// Top level of the array sorter: joins the controller and the datapath.
// Depends on asort_pkg, asort_ctrl and asort_datapath.
//
// Values are loaded one per clock into a 64-cell insertion chain, which keeps
// them in ascending order as they arrive. The transfer marked last closes the
// set, after which the chain shifts out one stored value per clock through a
// result register while the receiver does not stall. Values beyond 64 are
// dropped and the overflow flag is raised on every result of that set. No new
// values are taken while a set is emitted.
module array_sorter
   import asort_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   dp_cmd_type    cmd;
   dp_status_type status;

   asort_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_item (req_payload.last_item),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   asort_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/array_sorter_tb.sv =====
// Self-checking testbench for array_sorter: drives sets of signed values and
// checks every emitted value, flag and overflow bit against its own sort.
// Depends on asort_pkg and the array_sorter RTL.
module array_sorter_tb;
   import asort_pkg::*;

   localparam int NO_TRANSFER_LIMIT = 4000;
   localparam int DRAIN_CYCLES      = 20;
   localparam int ITEMS_PER_PHASE   = 85;
   localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

   class ascending_set_checker;
      logic signed [31:0] loaded_values[$];
      bit                 dropped_any;
      rsp_payload_type    due_results[$];
      int                 mismatches;

      function void take_element(req_payload_type item);
         int              pos;
         rsp_payload_type r;
         if (loaded_values.size() < MAX_ELEMENTS) begin
            pos = loaded_values.size();
            while (pos > 0 && $signed(loaded_values[pos - 1]) > $signed(item.value))
               pos--;
            loaded_values.insert(pos, item.value);
         end else begin
            dropped_any = 1'b1;
         end
         if (item.last_item) begin
            foreach (loaded_values[k]) begin
               r.sorted_value = loaded_values[k];
               r.last_result  = (k == loaded_values.size() - 1);
               r.overflowed   = dropped_any;
               due_results.push_back(r);
            end
            loaded_values.delete();
            dropped_any = 1'b0;
         end
      endfunction

      function void check_emitted(rsp_payload_type got);
         rsp_payload_type want;
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer: value %0d last %b overflow %b",
                        got.sorted_value, got.last_result, got.overflowed);
            return;
         end
         want = due_results.pop_front();
         if (got.sorted_value !== want.sorted_value || got.last_result !== want.last_result ||
             got.overflowed !== want.overflowed) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: value %0d/%0d last %b/%b overflow %b/%b (exp/got)",
                        want.sorted_value, got.sorted_value, want.last_result,
                        got.last_result, want.overflowed, got.overflowed);
         end
      endfunction
   endclass

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;

   int                   send_idle_pct  = 0;
   int                   recv_stall_pct = 0;
   int                   quiet_cycles   = 0;
   int                   phase_items;
   ascending_set_checker sorter_check   = new();

   array_sorter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sorter_check.take_element(req_payload);
         if (rsp_valid && rsp_ready)
            sorter_check.check_emitted(rsp_payload);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= NO_TRANSFER_LIMIT) begin
            $display("array_sorter_tb: FAIL");
            $finish;
         end
      end
   end

   task automatic send_value(input logic signed [31:0] value, input logic last_item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_payload.value     <= value;
      req_payload.last_item <= last_item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      phase_items++;
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 4))
               0:       return MOST_NEGATIVE;
               1:       return MOST_POSITIVE;
               2:       return 32'sd0;
               3:       return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         1:       return $signed(32'($urandom_range(0, 8))) - 32'sd4;
         default: return $signed($urandom());
      endcase
   endfunction

   task automatic send_set(input int size);
      for (int i = 0; i < size; i++)
         send_value(pick_value(), i == size - 1);
   endtask

   task automatic wait_until_emitted();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sorter_check.due_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int opening_size);
      int pick;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      phase_items    = 0;
      if (opening_size > 0)
         send_set(opening_size);
      while (phase_items < ITEMS_PER_PHASE) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            send_set($urandom_range(60, 70));
         else if (pick == 1)
            send_set(1);
         else
            send_set($urandom_range(2, 12));
      end
      wait_until_emitted();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_value(MOST_POSITIVE, 1'b0);
      send_value(MOST_NEGATIVE, 1'b0);
      send_value(32'sd0, 1'b0);
      send_value(-32'sd1, 1'b0);
      send_value(32'sd1, 1'b0);
      send_value(MOST_POSITIVE, 1'b0);
      send_value(MOST_NEGATIVE, 1'b1);
      send_value(32'sh5A5A_A5A5, 1'b1);
      send_value(32'sd5, 1'b0);
      send_value(32'sd4, 1'b0);
      send_value(32'sd3, 1'b0);
      send_value(-32'sd2, 1'b0);
      send_value(-32'sd3, 1'b1);
      send_value(32'sd7, 1'b0);
      send_value(32'sd7, 1'b0);
      send_value(32'sd7, 1'b1);
      wait_until_emitted();

      run_phase(0, 0, 65);
      run_phase(64, 0, 0);
      run_phase(0, 64, 64);
      run_phase(6, 6, 0);

      if (sorter_check.mismatches == 0 && sorter_check.due_results.size() == 0) begin
         $display("array_sorter_tb: PASS");
      end else begin
         $display("array_sorter_tb: FAIL");
      end
      $finish;
   end

endmodule
